// File: hw/rtl/rrwf_pkg.sv
// rrwf_pkg: shared types and constants for the row run-width filter
// no dependencies; imported by rrwf_cfg, rrwf_scan and row_run_width_filter_top
`default_nettype none

package rrwf_pkg;

	localparam int FIELD_W    = 12;
	localparam int PIXEL_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_LEN_W  = 13;

	localparam logic [PIXEL_W-1:0]   PIXEL_OPEN = 8'd255;
	localparam logic [PIXEL_W-1:0]   PIXEL_ZERO = 8'd0;
	localparam logic [FIELD_W-1:0]   ROW_MAX    = 12'd4095;

	localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST    = 13'd640;
	localparam logic [FIELD_W-1:0]   MIN_RUN_WIDTH_RST = 12'd4;
	localparam logic [FIELD_W-1:0]   MAX_RUN_WIDTH_RST = 12'd64;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH    = 2'd0,
		REG_MIN_RUN_WIDTH = 2'd1,
		REG_MAX_RUN_WIDTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] min_width;
		logic [FIELD_W-1:0] max_width;
	} width_limits_t;

	// result item, first field in the highest bits
	typedef struct packed {
		logic [FIELD_W-1:0] row_index;
		logic [FIELD_W-1:0] mid_col;
		logic [FIELD_W-1:0] end_col;
		logic [FIELD_W-1:0] start_col;
	} run_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/rrwf_cfg.sv
// rrwf_cfg: configuration registers and clamped last-column value
// depends on rrwf_pkg
`default_nettype none

module rrwf_cfg
	import rrwf_pkg::*;
#(
	parameter int MAX_COLUMNS = 4096,
	parameter int COL_W       = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic      [COL_W-1:0]      last_col,
	output width_limits_t              limits
);

	localparam int LEN_W = (COL_W + 1 > ROW_LEN_W) ? COL_W + 1 : ROW_LEN_W;

	logic [ROW_LEN_W-1:0] row_length_q;
	logic [FIELD_W-1:0]   min_width_q;
	logic [FIELD_W-1:0]   max_width_q;
	logic [LEN_W-1:0]     len_ext;
	logic [LEN_W-1:0]     len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			min_width_q  <= MIN_RUN_WIDTH_RST;
			max_width_q  <= MAX_RUN_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_LENGTH:    row_length_q <= cfg_data[ROW_LEN_W-1:0];
				REG_MIN_RUN_WIDTH: min_width_q  <= cfg_data[FIELD_W-1:0];
				REG_MAX_RUN_WIDTH: max_width_q  <= cfg_data[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// row length clamped to [2, MAX_COLUMNS]
	always_comb begin
		len_ext = LEN_W'(row_length_q);
		if (len_ext < LEN_W'(2))
			len_eff = LEN_W'(2);
		else if (len_ext > LEN_W'(MAX_COLUMNS))
			len_eff = LEN_W'(MAX_COLUMNS);
		else
			len_eff = len_ext;
	end

	assign last_col         = COL_W'(len_eff - LEN_W'(1));
	assign limits.min_width = min_width_q;
	assign limits.max_width = max_width_q;

endmodule

`default_nettype wire

// File: hw/rtl/rrwf_scan.sv
// rrwf_scan: column, row and run tracking with the width check for one pixel
// depends on rrwf_pkg
`default_nettype none

module rrwf_scan
	import rrwf_pkg::*;
#(
	parameter int COL_W = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic [PIXEL_W-1:0] pixel,
	input  wire logic               frame_start,
	input  wire logic [COL_W-1:0]   last_col,
	input  width_limits_t           limits,
	output logic                    hit,
	output run_result_t             result
);

	localparam int WIDTH_W = (COL_W > FIELD_W) ? COL_W : FIELD_W;

	logic [COL_W-1:0]   col_q;
	logic [FIELD_W-1:0] row_q;
	logic               open_q;
	logic [COL_W-1:0]   begin_q;

	logic [COL_W-1:0]   col;
	logic [FIELD_W-1:0] row;
	logic               open;
	logic               at_last;
	logic               close;
	logic [WIDTH_W-1:0] run_width;
	logic [COL_W:0]     col_sum;

	// frame start restarts counters and drops any open run
	assign col     = frame_start ? '0 : col_q;
	assign row     = frame_start ? '0 : row_q;
	assign open    = frame_start ? 1'b0 : open_q;
	assign at_last = (col >= last_col);
	assign close   = open && ((pixel == PIXEL_ZERO) || at_last);

	assign run_width = WIDTH_W'(col - begin_q);
	assign col_sum   = (COL_W+1)'(begin_q) + (COL_W+1)'(col);

	assign hit = close && (run_width >= WIDTH_W'(limits.min_width))
		&& (run_width <= WIDTH_W'(limits.max_width));

	assign result.start_col = FIELD_W'(begin_q);
	assign result.end_col   = FIELD_W'(col);
	assign result.mid_col   = FIELD_W'(col_sum >> 1);
	assign result.row_index = row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			open_q <= 1'b0;
		end else if (advance) begin
			if (open) begin
				if (close)
					open_q <= 1'b0;
				else
					open_q <= 1'b1;
			end else begin
				open_q <= (pixel == PIXEL_OPEN) && !at_last;
			end
			if (at_last) begin
				col_q <= '0;
				row_q <= (row < ROW_MAX) ? row + FIELD_W'(1) : row;
			end else begin
				col_q <= col + COL_W'(1);
				row_q <= row;
			end
		end
	end

	// run start column, only meaningful while a run is open
	always_ff @(posedge clk) begin
		if (advance && !open && (pixel == PIXEL_OPEN) && !at_last)
			begin_q <= col;
	end

endmodule

`default_nettype wire

// File: hw/rtl/row_run_width_filter_top.sv
// row_run_width_filter_top: stream wrapper with input and result registers
// depends on rrwf_pkg, rrwf_cfg, rrwf_scan
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   s_*     | in  | s_tvalid/s_tready  | tdata: pixel[7:0]; tuser: frame_start
//   m_*     | out | m_tvalid/m_tready  | tdata: start_col, end_col, mid_col, row_index
//   cfg_*   | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// one pixel per clock while results are taken; a pixel is held in the input register
// and its result is then loaded into the result register
// a pixel that closes no accepted run leaves no result and costs no output slot
// a stalled result only holds the scan when the input register is also full
// arst_n clears counters, run state, valid flags and loads register defaults
`default_nettype none

module row_run_width_filter_top
	import rrwf_pkg::*;
#(
	parameter int MAX_COLUMNS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] pixel
	input  wire logic                  s_tuser,   // [0] frame_start
	// run results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [47:0]                m_tdata,   // [11:0] start_col, [23:12] end_col,
	                                              // [35:24] mid_col, [47:36] row_index
	// register writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// column counter width follows the largest supported row
	localparam int COL_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;

	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic               frame_start_s1;

	logic               valid_s2;
	run_result_t        result_s2;

	logic               advance;
	logic               hit;
	run_result_t        result;
	logic [COL_W-1:0]   last_col;
	width_limits_t      limits;

	// the input register drains whenever the result slot is empty or being taken
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	rrwf_cfg #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.COL_W       (COL_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.last_col  (last_col),
		.limits    (limits)
	);

	rrwf_scan #(
		.COL_W (COL_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.pixel       (pixel_s1),
		.frame_start (frame_start_s1),
		.last_col    (last_col),
		.limits      (limits),
		.hit         (hit),
		.result      (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pixel_s1       <= s_tdata[PIXEL_W-1:0];
			frame_start_s1 <= s_tuser;
		end
	end

	// result register: loaded only by a pixel that closes an accepted run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= hit;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

endmodule

`default_nettype wire

// File: hw/rtl/rrwf_checker.sv
// rrwf_checker: port-level assertions for the row run-width filter
// no package needed; bound to row_run_width_filter_top
`default_nettype none

module rrwf_checker #(
	parameter int MAX_COLUMNS = 4096
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [47:0]           m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// nothing comes out of a block held in reset
	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid right after reset");

	// a fresh result must be preceded by a pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching pixel transfer");

	// midpoint lies between start and end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (MAX_COLUMNS <= 4096) |->
			(m_tdata[11:0] <= m_tdata[23:12]) && (m_tdata[35:24] >= m_tdata[11:0])
			&& (m_tdata[35:24] <= m_tdata[23:12]))
		else $error("run columns out of order");

endmodule

bind row_run_width_filter_top rrwf_checker #(
	.MAX_COLUMNS (MAX_COLUMNS)
) u_rrwf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

`default_nettype wire
